// ----- design/ucs_pkg.sv -----
// Shared types, constants and needle encoding for the UTF-8 character search block.
package ucs_pkg;

  localparam int MAX_NEEDLE_BYTES = 6;
  localparam int WIN_DEPTH        = MAX_NEEDLE_BYTES - 1;
  localparam int ENC_BYTES        = 6;
  localparam int LEN_W            = 3;
  localparam int DATA_W           = 32;
  localparam int CHAR_W           = 31;
  localparam int INDEX_W          = 2;

  localparam logic [INDEX_W-1:0] CFG_SEARCH_CHAR  = 2'd0;
  localparam logic [INDEX_W-1:0] CFG_SEARCH_LIMIT = 2'd1;
  localparam logic [INDEX_W-1:0] CFG_UNLIMITED    = 2'd2;

  typedef enum logic [1:0] {
    ST_SEARCH    = 2'd0,
    ST_FOUND     = 2'd1,
    ST_NOT_FOUND = 2'd2
  } status_t;

  typedef struct packed {
    logic [7:0] text_byte;
    logic       new_text;
  } in_item_t;

  typedef struct packed {
    status_t     status;
    logic [31:0] match_offset;
  } out_item_t;

  // Needle kept last byte first: rev[0] is the byte that completes a match.
  typedef struct packed {
    logic [ENC_BYTES-1:0][7:0] rev;
    logic [LEN_W-1:0]          len;
    logic [7:0]                lead;
    logic                      empty;
  } needle_t;

  function automatic needle_t encode_needle(input logic [CHAR_W-1:0] cp);
    needle_t          nd;
    logic [7:0]       lead_mark;
    logic [LEN_W-1:0] n;
    logic [35:0]      cpx;
    cpx = {5'b0, cp};
    priority if (cp < 31'h80) begin
      n = 3'd1; lead_mark = 8'h00;
    end else if (cp < 31'h800) begin
      n = 3'd2; lead_mark = 8'hc0;
    end else if (cp < 31'h10000) begin
      n = 3'd3; lead_mark = 8'he0;
    end else if (cp < 31'h200000) begin
      n = 3'd4; lead_mark = 8'hf0;
    end else if (cp < 31'h4000000) begin
      n = 3'd5; lead_mark = 8'hf8;
    end else begin
      n = 3'd6; lead_mark = 8'hfc;
    end
    for (int j = 0; j < ENC_BYTES; j++) begin
      if (LEN_W'(j) < n - 3'd1) begin
        nd.rev[j] = {2'b10, cpx[6*j +: 6]};
      end else if (LEN_W'(j) == n - 3'd1) begin
        nd.rev[j] = 8'(cpx >> (6 * j)) | lead_mark;
      end else begin
        nd.rev[j] = 8'h00;
      end
    end
    nd.len   = n;
    nd.lead  = nd.rev[n - 3'd1];
    nd.empty = (cp == '0);
    return nd;
  endfunction

endpackage

// ----- design/ucs_step.sv -----
// Search state (byte window, position, end flag) and the per-byte compare and update.
module ucs_step
  import ucs_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              step,
  input  in_item_t          item,
  input  needle_t           needle,
  input  logic [DATA_W-1:0] search_limit,
  input  logic              unlimited,
  output out_item_t         result
);

  logic [WIN_DEPTH-1:0][7:0] recent, recent_next, eff_recent;
  logic [31:0]               byte_position, byte_position_next, eff_pos;
  logic                      search_over, search_over_next, eff_over;

  logic limited, fits, hit_limit, match, too_late, ended, advance;

  always_comb begin
    // A new text clears the window and position before this byte is looked at.
    eff_over   = item.new_text ? 1'b0 : search_over;
    eff_pos    = item.new_text ? '0 : byte_position;
    eff_recent = item.new_text ? '0 : recent;

    limited   = !unlimited;
    fits      = needle.len <= LEN_W'(MAX_NEEDLE_BYTES);
    hit_limit = limited && (eff_pos >= search_limit);

    match = fits && (eff_pos >= 32'(needle.len - 3'd1))
            && (item.text_byte == needle.rev[0]);
    for (int k = 0; k < WIN_DEPTH; k++) begin
      if ((LEN_W'(k + 1) < needle.len) && (eff_recent[k] != needle.rev[k + 1])) begin
        match = 1'b0;
      end
    end

    too_late = fits && limited && (item.text_byte == needle.lead)
               && (({1'b0, eff_pos} + 33'(needle.len)) > {1'b0, search_limit});

    result.status       = ST_SEARCH;
    result.match_offset = '0;
    ended               = 1'b0;
    advance             = 1'b0;
    priority if (eff_over) begin
      ended = 1'b0;
    end else if (needle.empty) begin
      result.status = ST_FOUND;
      ended         = 1'b1;
    end else if (hit_limit || (item.text_byte == 8'h00)) begin
      result.status = ST_NOT_FOUND;
      ended         = 1'b1;
    end else if (match) begin
      result.status       = ST_FOUND;
      result.match_offset = eff_pos - 32'(needle.len - 3'd1);
      ended               = 1'b1;
    end else if (too_late) begin
      result.status = ST_NOT_FOUND;
      ended         = 1'b1;
    end else begin
      advance = 1'b1;
    end

    search_over_next   = eff_over | ended;
    byte_position_next = eff_pos;
    recent_next        = eff_recent;
    if (advance) begin
      recent_next = {eff_recent[WIN_DEPTH-2:0], item.text_byte};
      if (eff_pos != '1) begin
        byte_position_next = eff_pos + 32'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      recent        <= '0;
      byte_position <= '0;
      search_over   <= 1'b1;
    end else if (step) begin
      recent        <= recent_next;
      byte_position <= byte_position_next;
      search_over   <= search_over_next;
    end
  end

endmodule

// ----- design/utf8_char_search_unit.sv -----
// Top level of the UTF-8 character search block: configuration, input and result stages.
//
// Usage:
//   Program search_char (index 0), search_limit (index 1) and unlimited (index 2)
//   through the write port while no transaction is in flight. The code point is
//   encoded to its UTF-8 form (1 to 6 bytes) at the write, so the needle is ready
//   for the next text byte.
//   Text bytes enter on the text channel, one transaction per byte; new_text marks
//   the first byte of a text. Every text transaction yields exactly one result
//   transaction: status searching/idle, found with the match start offset, or not
//   found. After found or not found, bytes return the idle status until new_text.
//   The byte waits in the input register and the compare loads the result register.
//   Throughput: one byte per cycle while the result is not stalled, set by the
//   single compare stage between the input and result registers.
//   Reset: registers return to search_char 0, search_limit 0, unlimited 1; the
//   search waits for a new text; both pipeline stages empty.
//   Stall: while result_ready is low the result holds; one more byte is taken into
//   the input register, then text_ready drops until the result moves.
module utf8_char_search_unit
  import ucs_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               text_valid,
  output logic               text_ready,
  input  in_item_t           text,
  output logic               result_valid,
  input  logic               result_ready,
  output out_item_t          result,
  input  logic               cfg_write_en,
  input  logic [INDEX_W-1:0] cfg_index,
  input  logic [DATA_W-1:0]  cfg_data
);

  // Configuration: the needle is stored already encoded.
  needle_t           needle;
  logic [DATA_W-1:0] search_limit;
  logic              unlimited;

  always_ff @(posedge clk) begin
    if (rst) begin
      needle       <= encode_needle('0);
      search_limit <= '0;
      unlimited    <= 1'b1;
    end else if (cfg_write_en) begin
      unique case (cfg_index)
        CFG_SEARCH_CHAR:  needle       <= encode_needle(cfg_data[CHAR_W-1:0]);
        CFG_SEARCH_LIMIT: search_limit <= cfg_data;
        CFG_UNLIMITED:    unlimited    <= cfg_data[0];
        default:          ;  // drop writes beyond the register list
      endcase
    end
  end

  // Input register and result register; the step fires when a byte moves
  // from the first into the second.
  logic      s1_valid;
  in_item_t  s1_item;
  logic      out_load;
  logic      step;
  out_item_t step_result;

  assign out_load   = !result_valid || result_ready;
  assign step       = s1_valid && out_load;
  assign text_ready = !s1_valid || out_load;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (text_ready) begin
      s1_valid <= text_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (text_valid && text_ready) begin
      s1_item <= text;
    end
  end

  ucs_step u_step (
    .clk          (clk),
    .rst          (rst),
    .step         (step),
    .item         (s1_item),
    .needle       (needle),
    .search_limit (search_limit),
    .unlimited    (unlimited),
    .result       (step_result)
  );

  // Hold the result while the receiver stalls; advance otherwise.
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (out_load) begin
      result_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      result <= step_result;
    end
  end

endmodule

// ----- design/ucs_checker.sv -----
// Port-level checks for the UTF-8 character search block, bound to its top level.
module ucs_checker
  import ucs_pkg::*;
(
  input logic               clk,
  input logic               rst,
  input logic               text_ready,
  input logic               result_valid,
  input logic               result_ready,
  input out_item_t          result
);

  a_result_hold: assert property (@(posedge clk) disable iff (rst)
    result_valid && !result_ready |=> result_valid && $stable(result))
    else $error("result changed while stalled");

  a_offset_zero: assert property (@(posedge clk) disable iff (rst)
    result_valid && (result.status != ST_FOUND) |-> result.match_offset == '0)
    else $error("offset set without a match");

  a_ready_stall: assert property (@(posedge clk) disable iff (rst)
    !text_ready |-> result_valid)
    else $error("text channel stalled with no result pending");

  a_reset_empty: assert property (@(posedge clk)
    $past(rst) |-> !result_valid)
    else $error("result valid right after reset");

endmodule

bind utf8_char_search_unit ucs_checker u_ucs_checker (.*);
